FILE: sv/assert_macros.svh
// Assertion macros used by csv_byte_tokenizer_unit, the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/csvt_pkg.sv
// ----------------------------------------------------------------------------
// csvt_pkg
// Types and constants of the CSV byte tokeniser.
// ----------------------------------------------------------------------------
`default_nettype none

package csvt_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int unsigned MaxEvents = 4;

  typedef enum logic [2:0] {
    M_ROW        = 3'd0,
    M_AFTER_LF   = 3'd1,
    M_AFTER_CR   = 3'd2,
    M_ABSORB_CR  = 3'd3,
    M_AFTER_COMMA= 3'd4,
    M_PLAIN      = 3'd5,
    M_QUOTED     = 3'd6,
    M_QUOTE_SEEN = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    EV_BYTE  = 2'd0,
    EV_FIELD = 2'd1,
    EV_ROW   = 2'd2
  } event_kind_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  data;
    logic        nul;
  } event_t;

  // Everything one byte does: the new scan state and its list of events.
  typedef struct packed {
    mode_t                    mode_next;
    logic                     fhb_next;
    logic [2:0]               count;
    event_t [MaxEvents-1:0]   ev;
  } decode_t;

  function automatic event_t mk_event(event_kind_t kind, logic [7:0] data, logic nul);
    event_t e;
    e.kind = kind;
    e.data = data;
    e.nul  = nul;
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: sv/csvt_decode.sv
// ----------------------------------------------------------------------------
// csvt_decode
// Combinational step of the tokeniser: scan state and one byte in, next
// state and up to four events out.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_decode (
  input  csvt_pkg::mode_t   mode_in,
  input  logic              fhb_in,
  input  logic [7:0]        byte_in,
  input  logic              fin_in,
  output csvt_pkg::decode_t dec
);
  import csvt_pkg::*;

  mode_t                  mode;
  logic                   fhb;
  logic [2:0]             n;
  event_t [MaxEvents-1:0] ev;
  logic                   do_begin;
  logic                   do_after;

  always_comb begin
    mode     = mode_in;
    fhb      = fhb_in;
    n        = 3'd0;
    ev       = '0;
    do_begin = 1'b0;
    do_after = 1'b0;

    case (mode_in)
      M_QUOTE_SEEN: begin
        if (byte_in == CH_QUOTE) begin
          ev[n[1:0]] = mk_event(EV_BYTE, CH_QUOTE, 1'b0);
          n = n + 3'd1;
          fhb  = 1'b1;
          mode = M_QUOTED;
        end else begin
          ev[n[1:0]] = mk_event(EV_FIELD, 8'h00, !fhb);
          n = n + 3'd1;
          fhb = 1'b0;
          if (byte_in == CH_COMMA) begin
            mode = M_AFTER_COMMA;
          end else begin
            do_begin = 1'b1;
          end
        end
      end
      M_QUOTED: begin
        if (byte_in == CH_QUOTE) begin
          mode = M_QUOTE_SEEN;
        end else begin
          ev[n[1:0]] = mk_event(EV_BYTE, byte_in, 1'b0);
          n = n + 3'd1;
          fhb = 1'b1;
        end
      end
      M_PLAIN: begin
        if (byte_in == CH_COMMA || byte_in == CH_CR || byte_in == CH_LF) begin
          ev[n[1:0]] = mk_event(EV_FIELD, 8'h00, !fhb);
          n = n + 3'd1;
          fhb = 1'b0;
          if (byte_in == CH_COMMA) begin
            mode = M_AFTER_COMMA;
          end else begin
            ev[n[1:0]] = mk_event(EV_ROW, 8'h00, 1'b0);
            n = n + 3'd1;
            mode = (byte_in == CH_CR) ? M_AFTER_CR : M_AFTER_LF;
          end
        end else begin
          ev[n[1:0]] = mk_event(EV_BYTE, byte_in, 1'b0);
          n = n + 3'd1;
          fhb = 1'b1;
        end
      end
      M_ABSORB_CR: begin
        if (byte_in == CH_LF) begin
          mode = M_ROW;
        end else begin
          ev[n[1:0]] = mk_event(EV_ROW, 8'h00, 1'b0);
          n = n + 3'd1;
          do_after = 1'b1;
        end
      end
      M_AFTER_CR: begin
        if (byte_in == CH_LF) begin
          mode = M_AFTER_LF;
        end else begin
          do_after = 1'b1;
        end
      end
      M_AFTER_LF: begin
        do_after = 1'b1;
      end
      default: begin
        do_begin = 1'b1;
      end
    endcase

    // A CR straight after a row break may be the start of an absorbed CR LF.
    if (do_after) begin
      if (byte_in == CH_CR) begin
        mode = M_ABSORB_CR;
      end else begin
        do_begin = 1'b1;
      end
    end

    if (do_begin) begin
      if (byte_in == CH_COMMA) begin
        ev[n[1:0]] = mk_event(EV_FIELD, 8'h00, 1'b1);
        n = n + 3'd1;
        mode = M_AFTER_COMMA;
      end else if (byte_in == CH_CR) begin
        ev[n[1:0]] = mk_event(EV_ROW, 8'h00, 1'b0);
        n = n + 3'd1;
        mode = M_AFTER_CR;
      end else if (byte_in == CH_LF) begin
        ev[n[1:0]] = mk_event(EV_ROW, 8'h00, 1'b0);
        n = n + 3'd1;
        mode = M_AFTER_LF;
      end else if (byte_in == CH_QUOTE) begin
        fhb  = 1'b0;
        mode = M_QUOTED;
      end else begin
        ev[n[1:0]] = mk_event(EV_BYTE, byte_in, 1'b0);
        n = n + 3'd1;
        fhb  = 1'b1;
        mode = M_PLAIN;
      end
    end

    // The last byte of a text closes whatever is open and restarts the scan.
    if (fin_in) begin
      if (mode == M_PLAIN || mode == M_QUOTED || mode == M_QUOTE_SEEN) begin
        ev[n[1:0]] = mk_event(EV_FIELD, 8'h00, !fhb);
        n = n + 3'd1;
        ev[n[1:0]] = mk_event(EV_ROW, 8'h00, 1'b0);
        n = n + 3'd1;
      end else if (mode == M_AFTER_COMMA || mode == M_ABSORB_CR) begin
        ev[n[1:0]] = mk_event(EV_ROW, 8'h00, 1'b0);
        n = n + 3'd1;
      end
      mode = M_ROW;
      fhb  = 1'b0;
    end

    dec.mode_next = mode;
    dec.fhb_next  = fhb;
    dec.count     = n;
    dec.ev        = ev;
  end

endmodule

`default_nettype wire

FILE: sv/csv_byte_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// csv_byte_tokenizer_unit
// Streams CSV text a byte at a time and emits content, field-end and row-end
// events.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_ready  in_byte, final_byte
//   out      out_valid / out_ready event_kind, data_byte, null_field,
//                                 last_of_run
//
// A byte is held in an input register, decoded combinationally into up to
// four events, and the events leave one beat per cycle from the event buffer
// while out_ready is high. A byte giving more than one event holds the input
// side while the event buffer drains.
// Reset clears the scan state and both buffers; a stalled output holds the
// input register, and one more byte may wait in it.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_byte_tokenizer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] event_kind,
  output logic [7:0] data_byte,
  output logic       null_field,
  output logic       last_of_run
);
  import csvt_pkg::*;

  // Input register.
  logic       inq_valid;
  logic [7:0] inq_byte;
  logic       inq_fin;

  // Scan state.
  mode_t mode;
  logic  fhb;

  // Event buffer.
  event_t [MaxEvents-1:0] evbuf;
  logic [2:0]             rem;
  logic [1:0]             rd;

  decode_t dec;
  logic    load;
  logic    out_take;
  event_t  cur;

  csvt_decode u_decode (
    .mode_in (mode),
    .fhb_in  (fhb),
    .byte_in (inq_byte),
    .fin_in  (inq_fin),
    .dec     (dec)
  );

  assign out_take = out_valid && out_ready;
  assign load     = inq_valid && (rem == 3'd0 || (rem == 3'd1 && out_ready));
  assign in_ready = !inq_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inq_byte <= in_byte;
      inq_fin  <= final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_ROW;
      fhb  <= 1'b0;
    end else if (load) begin
      mode <= dec.mode_next;
      fhb  <= dec.fhb_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
      rd  <= 2'd0;
    end else if (load) begin
      rem <= dec.count;
      rd  <= 2'd0;
    end else if (out_take) begin
      rem <= rem - 3'd1;
      rd  <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      evbuf <= dec.ev;
    end
  end

  assign cur         = evbuf[rd];
  assign out_valid   = (rem != 3'd0);
  assign event_kind  = cur.kind;
  assign data_byte   = cur.data;
  assign null_field  = cur.nul;
  assign last_of_run = (rem == 3'd1);

`include "assert_macros.svh"

  `ASSERT_IMP(a_load_free, clk, rst, load && rem != 3'd0, out_take && last_of_run, "event overrun")
  `ASSERT_NXT(a_run_continues, clk, rst, out_take && !last_of_run, out_valid, "run broken early")
  `ASSERT_NXT(a_fin_clears, clk, rst, load && inq_fin, mode == M_ROW && !fhb, "scan not reset")
  `ASSERT_IMP(a_kind_valid, clk, rst, out_valid, event_kind != 2'd3, "undefined event kind")

endmodule

`default_nettype wire
